[src/lpn_pkg.sv]
// ----------------------------------------------------------------------------
// lpn_pkg
// Shared constants, types and helpers of the lexical path normalizer:
// character codes, store geometry, controller states and the command and
// status groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
package lpn_pkg;

  // Store geometry
  localparam int MAX_LEN = 64;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int CHAR_W  = 8;

  typedef logic [ADDR_W-1:0] pos_t;
  typedef logic [CHAR_W-1:0] char_t;

  // Highest count of stored characters; more are dropped and flagged
  localparam pos_t LAST_CNT = ADDR_W'(MAX_LEN - 1);
  localparam pos_t POS_ZERO = '0;
  localparam pos_t POS_ONE  = ADDR_W'(1);

  // Character codes
  localparam char_t CH_SLASH  = 8'h2F;
  localparam char_t CH_BSLASH = 8'h5C;
  localparam char_t CH_DOT    = 8'h2E;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_END,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_FIX,
    ST_EMIT_RD,
    ST_EMIT_LD
  } lpn_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic take;      // accept the input item
    logic end_comp;  // close the current component
    logic walk_rd;   // read the character before the walk pointer
    logic walk_chk;  // check the character read during the walk
    logic fix;       // turn an empty result into a dot
    logic emit_rd;   // read the next result character
    logic emit_ld;   // load the output register
  } lpn_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic in_last;   // input item closes the path
    logic sep_end;   // input item is a separator that closes a component
    logic pop;       // closing component is a dot-dot that pops
    logic walk_done; // walk reached the previous separator or the start
    logic out_free;  // output register can take a new item
    logic emit_last; // next loaded character is the final one
  } lpn_sts_t;

  function automatic logic is_sep(input char_t c);
    return (c == CH_SLASH) || (c == CH_BSLASH);
  endfunction

endpackage

[src/lpn_if.sv]
// ----------------------------------------------------------------------------
// lpn_if
// Valid/ready channels of the lexical path normalizer: one for input
// characters and one for result characters.
// ----------------------------------------------------------------------------
interface lpn_in_if;
  logic                 valid;
  logic                 ready;
  lpn_pkg::char_t       in_char;
  logic                 has_char;
  logic                 in_last;

  modport source (output valid, output in_char, output has_char, output in_last,
                  input ready);
  modport sink   (input valid, input in_char, input has_char, input in_last,
                  output ready);
endinterface

interface lpn_out_if;
  logic                 valid;
  logic                 ready;
  lpn_pkg::char_t       out_char;
  logic                 out_last;
  logic                 overflow;

  modport source (output valid, output out_char, output out_last, output overflow,
                  input ready);
  modport sink   (input valid, input out_char, input out_last, input overflow,
                  output ready);
endinterface

[src/lpn_ctrl.sv]
// ----------------------------------------------------------------------------
// lpn_ctrl
// Sequencer of the normalizer: takes input items, closes components, runs
// the backward walk of a dot-dot pop and steps the result run.
// ----------------------------------------------------------------------------
module lpn_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lpn_pkg::lpn_sts_t sts,
  output lpn_pkg::lpn_cmd_t cmd
);

  lpn_pkg::lpn_state_t state_r, state_nxt;
  logic                last_r, last_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    case (state_r)
      lpn_pkg::ST_IDLE: begin
        if (in_valid) begin
          last_nxt = sts.in_last;
          if (sts.in_last || sts.sep_end) begin
            state_nxt = lpn_pkg::ST_END;
          end
        end
      end
      lpn_pkg::ST_END: begin
        if (sts.pop) begin
          state_nxt = lpn_pkg::ST_WALK_RD;
        end else if (last_r) begin
          state_nxt = lpn_pkg::ST_FIX;
        end else begin
          state_nxt = lpn_pkg::ST_IDLE;
        end
      end
      lpn_pkg::ST_WALK_RD: begin
        state_nxt = lpn_pkg::ST_WALK_CHK;
      end
      lpn_pkg::ST_WALK_CHK: begin
        if (!sts.walk_done) begin
          state_nxt = lpn_pkg::ST_WALK_RD;
        end else if (last_r) begin
          state_nxt = lpn_pkg::ST_FIX;
        end else begin
          state_nxt = lpn_pkg::ST_IDLE;
        end
      end
      lpn_pkg::ST_FIX: begin
        state_nxt = lpn_pkg::ST_EMIT_RD;
      end
      lpn_pkg::ST_EMIT_RD: begin
        state_nxt = lpn_pkg::ST_EMIT_LD;
      end
      lpn_pkg::ST_EMIT_LD: begin
        if (sts.out_free) begin
          state_nxt = sts.emit_last ? lpn_pkg::ST_IDLE : lpn_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = lpn_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      lpn_pkg::ST_IDLE: begin
        in_ready = rst_n;
        cmd.take = in_valid && rst_n;
      end
      lpn_pkg::ST_END:      cmd.end_comp = 1'b1;
      lpn_pkg::ST_WALK_RD:  cmd.walk_rd  = 1'b1;
      lpn_pkg::ST_WALK_CHK: cmd.walk_chk = 1'b1;
      lpn_pkg::ST_FIX:      cmd.fix      = 1'b1;
      lpn_pkg::ST_EMIT_RD:  cmd.emit_rd  = 1'b1;
      lpn_pkg::ST_EMIT_LD:  cmd.emit_ld  = sts.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpn_pkg::ST_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

[src/lpn_dpath.sv]
// ----------------------------------------------------------------------------
// lpn_dpath
// Datapath of the normalizer: the cleaned-path store, write and walk
// pointers, component tracking and the output register.
// ----------------------------------------------------------------------------
module lpn_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  lpn_pkg::lpn_cmd_t cmd,
  output lpn_pkg::lpn_sts_t sts,
  input  lpn_pkg::char_t    in_char,
  input  logic              has_char,
  input  logic              in_last,
  input  logic              out_ready,
  output logic              out_valid,
  output lpn_pkg::char_t    out_char,
  output logic              out_last,
  output logic              overflow
);

  // Cleaned path store
  lpn_pkg::char_t clean_mem [lpn_pkg::MAX_LEN];

  // Path state
  lpn_pkg::pos_t  cnt_r,  cnt_nxt;   // characters taken for this path
  logic           abs_r,  abs_nxt;   // path starts at the root
  logic           ovf_r,  ovf_nxt;   // a character was dropped
  lpn_pkg::pos_t  w_r,    w_nxt;     // length of the committed result
  lpn_pkg::pos_t  t_r,    t_nxt;     // write position inside the open component
  lpn_pkg::pos_t  base_r, base_nxt;  // end of the root or the kept dot-dot prefix
  lpn_pkg::pos_t  back_r, back_nxt;  // walk pointer of a pop
  lpn_pkg::pos_t  k_r,    k_nxt;     // result read pointer
  logic [1:0]     clen_r, clen_nxt;  // open component length, saturating
  logic           d0_r,   d0_nxt;    // first component character is a dot
  logic           d1_r,   d1_nxt;    // second component character is a dot

  lpn_pkg::char_t rd_data_r;
  logic           out_valid_r, out_valid_nxt;
  lpn_pkg::char_t out_char_r;
  logic           out_last_r;
  logic           out_ovf_r;

  logic           c_sep, c_store, c_first;
  logic           need_slash;
  lpn_pkg::pos_t  comp_pos;
  logic           is_dot, is_dd, pop, commit;
  logic           walk_done;
  lpn_pkg::pos_t  walk_w;
  logic           out_free, emit_last;

  logic           we, re;
  lpn_pkg::pos_t  wa, ra;
  lpn_pkg::char_t wd;

  // Decode the input character and the open component
  always_comb begin
    c_sep      = lpn_pkg::is_sep(in_char);
    c_store    = has_char && (cnt_r != lpn_pkg::LAST_CNT);
    c_first    = (cnt_r == lpn_pkg::POS_ZERO);
    need_slash = (w_r > {{(lpn_pkg::ADDR_W-1){1'b0}}, abs_r});
    comp_pos   = (clen_r == 2'd0) ? (w_r + lpn_pkg::pos_t'(need_slash)) : t_r;
    is_dot     = (clen_r == 2'd1) && d0_r;
    is_dd      = (clen_r == 2'd2) && d0_r && d1_r;
    pop        = is_dd && (w_r > base_r);
    commit     = (clen_r != 2'd0) && !is_dot && (!is_dd || (!pop && !abs_r));
    walk_done  = (back_r == lpn_pkg::POS_ZERO) || (rd_data_r == lpn_pkg::CH_SLASH);
    walk_w     = (back_r <= lpn_pkg::POS_ONE) ? {{(lpn_pkg::ADDR_W-1){1'b0}}, abs_r}
                                              : (back_r - lpn_pkg::POS_ONE);
    out_free   = !out_valid_r || out_ready;
    emit_last  = (k_r == (w_r - lpn_pkg::POS_ONE));
  end

  always_comb begin
    sts.in_last   = in_last;
    sts.sep_end   = c_store && c_sep && !c_first;
    sts.pop       = pop;
    sts.walk_done = walk_done;
    sts.out_free  = out_free;
    sts.emit_last = emit_last;
  end

  // Store write and read port selection
  always_comb begin
    we = 1'b0;
    wa = w_r;
    wd = lpn_pkg::CH_SLASH;
    re = 1'b0;
    ra = k_r;
    if (cmd.take && c_store) begin
      if (c_first && c_sep) begin
        we = 1'b1;
        wa = lpn_pkg::POS_ZERO;
      end else if (!c_sep) begin
        we = 1'b1;
        wa = comp_pos;
        wd = in_char;
      end
    end
    if (cmd.end_comp && commit && need_slash) begin
      we = 1'b1;
    end
    if (cmd.fix && (w_r == lpn_pkg::POS_ZERO)) begin
      we = 1'b1;
      wa = lpn_pkg::POS_ZERO;
      wd = lpn_pkg::CH_DOT;
    end
    if (cmd.walk_rd) begin
      re = 1'b1;
      ra = back_r - lpn_pkg::POS_ONE;
    end
    if (cmd.emit_rd) begin
      re = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      clean_mem[wa] <= wd;
    end
    if (re) begin
      rd_data_r <= clean_mem[ra];
    end
  end

  // Advance the path state
  always_comb begin
    cnt_nxt       = cnt_r;
    abs_nxt       = abs_r;
    ovf_nxt       = ovf_r;
    w_nxt         = w_r;
    t_nxt         = t_r;
    base_nxt      = base_r;
    back_nxt      = back_r;
    k_nxt         = k_r;
    clen_nxt      = clen_r;
    d0_nxt        = d0_r;
    d1_nxt        = d1_r;
    out_valid_nxt = out_valid_r;

    // Take a character: open the root or extend the open component
    if (cmd.take) begin
      if (has_char && !c_store) begin
        ovf_nxt = 1'b1;
      end
      if (c_store) begin
        cnt_nxt = cnt_r + lpn_pkg::POS_ONE;
        if (c_first && c_sep) begin
          abs_nxt  = 1'b1;
          w_nxt    = lpn_pkg::POS_ONE;
          base_nxt = lpn_pkg::POS_ONE;
        end else if (!c_sep) begin
          t_nxt    = comp_pos + lpn_pkg::POS_ONE;
          clen_nxt = (clen_r == 2'd3) ? 2'd3 : (clen_r + 2'd1);
          if (clen_r == 2'd0) begin
            d0_nxt = (in_char == lpn_pkg::CH_DOT);
          end
          if (clen_r == 2'd1) begin
            d1_nxt = (in_char == lpn_pkg::CH_DOT);
          end
        end
      end
    end

    // Close the component: drop a dot, keep or pop a dot-dot, commit a name
    if (cmd.end_comp) begin
      clen_nxt = 2'd0;
      if (commit) begin
        w_nxt = t_r;
        if (is_dd) begin
          base_nxt = t_r;
        end
      end
      if (pop) begin
        back_nxt = w_r;
      end
    end

    // Walk back to the separator before the popped component
    if (cmd.walk_chk) begin
      if (walk_done) begin
        w_nxt = walk_w;
      end else begin
        back_nxt = back_r - lpn_pkg::POS_ONE;
      end
    end

    if (cmd.fix) begin
      k_nxt = lpn_pkg::POS_ZERO;
      if (w_r == lpn_pkg::POS_ZERO) begin
        w_nxt = lpn_pkg::POS_ONE;
      end
    end

    // Hand a result character to the output and clear after the final one
    if (cmd.emit_ld) begin
      out_valid_nxt = 1'b1;
      k_nxt         = k_r + lpn_pkg::POS_ONE;
      if (emit_last) begin
        cnt_nxt  = lpn_pkg::POS_ZERO;
        abs_nxt  = 1'b0;
        ovf_nxt  = 1'b0;
        w_nxt    = lpn_pkg::POS_ZERO;
        base_nxt = lpn_pkg::POS_ZERO;
        clen_nxt = 2'd0;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= lpn_pkg::POS_ZERO;
      abs_r       <= 1'b0;
      ovf_r       <= 1'b0;
      w_r         <= lpn_pkg::POS_ZERO;
      t_r         <= lpn_pkg::POS_ZERO;
      base_r      <= lpn_pkg::POS_ZERO;
      back_r      <= lpn_pkg::POS_ZERO;
      k_r         <= lpn_pkg::POS_ZERO;
      clen_r      <= 2'd0;
      d0_r        <= 1'b0;
      d1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      abs_r       <= abs_nxt;
      ovf_r       <= ovf_nxt;
      w_r         <= w_nxt;
      t_r         <= t_nxt;
      base_r      <= base_nxt;
      back_r      <= back_nxt;
      k_r         <= k_nxt;
      clen_r      <= clen_nxt;
      d0_r        <= d0_nxt;
      d1_r        <= d1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      out_char_r <= rd_data_r;
      out_last_r <= emit_last;
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;
  assign overflow  = out_ovf_r;

endmodule

[src/lexical_path_normalizer_core.sv]
// ----------------------------------------------------------------------------
// lexical_path_normalizer_core
// Lexical path cleaner: takes a path one character per item and returns the
// cleaned path as a run of characters when the item marked last arrives.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries in_char, has_char and in_last. Items with has_char low
//          store nothing; in_last closes the path.
//   out_ch carries one cleaned character per item, out_last on the final
//          one and overflow on every item of a path that had more than
//          MAX_LEN-1 characters (the excess is dropped).
// Sequence:
//   A name character, a leading or dropped separator or an empty item is
//   taken in the idle state alone; a later separator also passes the close
//   state, where the component closes. A dot-dot that pops then walks back,
//   reading and checking each character of the popped component and then
//   the separator or path start before it. The last item passes take, close
//   and the empty-path check plus any walk, then each result character takes
//   a store read and an output register load while out_ch is ready.
// Reset clears the control state and holds in_ch not ready; the store needs
// no clearing. When the receiver stalls, the output register holds its item
// and the run pauses; once the final character sits in the output register,
// the next path is taken in while that item waits.
// ----------------------------------------------------------------------------
module lexical_path_normalizer_core (
  input  logic      clk,
  input  logic      rst_n,
  lpn_in_if.sink    in_ch,
  lpn_out_if.source out_ch
);

  lpn_pkg::lpn_cmd_t cmd;
  lpn_pkg::lpn_sts_t sts;

  lpn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lpn_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_char   (in_ch.in_char),
    .has_char  (in_ch.has_char),
    .in_last   (in_ch.in_last),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_char  (out_ch.out_char),
    .out_last  (out_ch.out_last),
    .overflow  (out_ch.overflow)
  );

endmodule

[src/lpn_checker.sv]
// ----------------------------------------------------------------------------
// lpn_checker
// Port-level checks of the lexical path normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module lpn_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           has_char,
  input logic           in_last,
  input logic           out_valid,
  input logic           out_ready,
  input lpn_pkg::char_t out_char,
  input logic           out_last
);

  // Hold a stalled result item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_char) && $stable(out_last)))
    else $error("stalled result item changed");

  // Stop taking items once a path is closed
  a_last_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last) |=> !in_ready)
    else $error("input taken right after the last item of a path");

  // Keep taking items after an empty item inside a path
  a_empty_item_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !has_char && !in_last) |=> in_ready)
    else $error("empty item stalled the input");

  // Drop all results at reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item visible after reset");

endmodule

bind lexical_path_normalizer_core lpn_checker u_lpn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .has_char  (in_ch.has_char),
  .in_last   (in_ch.in_last),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_char  (out_ch.out_char),
  .out_last  (out_ch.out_last)
);

[bench/lpn_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lpn_scoreboard
// Watches both channels of the path normalizer, keeps its own model of the
// character store, cleans each finished path and compares every result item,
// field by field, with the oldest predicted character.
// ----------------------------------------------------------------------------
module lpn_scoreboard (
  input  logic clk,
  input  logic rst_n,
  lpn_in_if    in_mon,
  lpn_out_if   out_mon,
  output int   fail_count,
  output int   pending,
  output int   paths_done,
  output int   results_seen
);

  localparam int TIDY_SIZE = lpn_pkg::MAX_LEN + 4;
  localparam int RUN_LIMIT = 64;

  typedef struct packed {
    lpn_pkg::char_t ch;
    logic           last;
    logic           ovf;
  } clean_char_t;

  // Model state: raw characters of the open path
  lpn_pkg::char_t path_chars [lpn_pkg::MAX_LEN];
  int             char_count;
  logic           path_absolute;
  logic           path_truncated;

  // Cleaned path under construction
  lpn_pkg::char_t tidy_buf [TIDY_SIZE];

  clean_char_t expected_chars[$];
  int          fails;
  int          paths;
  int          seen;

  function automatic logic is_divider(input lpn_pkg::char_t c);
    return (c == lpn_pkg::CH_SLASH) || (c == lpn_pkg::CH_BSLASH);
  endfunction

  // Append one character unless the buffer is full; return the new length
  function automatic int put_tidy(input int w, input lpn_pkg::char_t c);
    if (w < TIDY_SIZE) begin
      tidy_buf[w] = c;
      return w + 1;
    end
    return w;
  endfunction

  // Clean the stored path into tidy_buf and return its length
  function automatic int build_tidy();
    int len;
    int w;
    int r;
    int floor_pos;
    int start;
    int clen;
    int back;
    len = char_count;
    w = 0;
    r = 0;
    if (path_absolute && len > 0) begin
      tidy_buf[0] = lpn_pkg::CH_SLASH;
      w = 1;
      r = 1;
    end
    floor_pos = path_absolute ? 1 : 0;
    while (r < len) begin
      // skip the separator run
      while (r < len && is_divider(path_chars[r])) r++;
      if (r >= len) break;
      start = r;
      while (r < len && !is_divider(path_chars[r])) r++;
      clen = r - start;

      // drop a single dot
      if (clen == 1 && path_chars[start] == lpn_pkg::CH_DOT) continue;

      // dot-dot: pop, keep at root of a relative path, or append after a kept one
      if (clen == 2 && path_chars[start] == lpn_pkg::CH_DOT &&
          path_chars[start+1] == lpn_pkg::CH_DOT) begin
        if (w > floor_pos) begin
          back = w;
          while (back > 0 && tidy_buf[back-1] != lpn_pkg::CH_SLASH) back--;
          if (path_absolute && back == 0) back = 1;
          if (w - back == 2 && tidy_buf[back] == lpn_pkg::CH_DOT &&
              tidy_buf[back+1] == lpn_pkg::CH_DOT) begin
            w = put_tidy(w, lpn_pkg::CH_SLASH);
            w = put_tidy(w, lpn_pkg::CH_DOT);
            w = put_tidy(w, lpn_pkg::CH_DOT);
          end else begin
            w = back;
            if (w > 0 && tidy_buf[w-1] == lpn_pkg::CH_SLASH) w--;
            if (w == 0 && path_absolute) w = 1;
          end
        end else if (!path_absolute) begin
          if (w > 0) w = put_tidy(w, lpn_pkg::CH_SLASH);
          w = put_tidy(w, lpn_pkg::CH_DOT);
          w = put_tidy(w, lpn_pkg::CH_DOT);
        end
        continue;
      end

      // ordinary name: join with a slash, then copy
      if (w > 0 && tidy_buf[w-1] != lpn_pkg::CH_SLASH)
        w = put_tidy(w, lpn_pkg::CH_SLASH);
      for (int i = 0; i < clen; i++) w = put_tidy(w, path_chars[start+i]);
    end
    if (w == 0) w = put_tidy(w, lpn_pkg::CH_DOT);
    return w;
  endfunction

  // Store one input item; on the closing item predict the cleaned run
  task automatic absorb_item(input lpn_pkg::char_t c, input logic has, input logic last);
    int n;
    clean_char_t cc;
    if (has) begin
      if (char_count < lpn_pkg::MAX_LEN - 1) begin
        if (char_count == 0) path_absolute = is_divider(c);
        path_chars[char_count] = c;
        char_count++;
      end else begin
        path_truncated = 1'b1;
      end
    end
    if (last) begin
      n = build_tidy() & 8'h7F;
      if (n > RUN_LIMIT) n = RUN_LIMIT;
      for (int k = 0; k < n; k++) begin
        cc.ch   = tidy_buf[k];
        cc.last = (k + 1 == n);
        cc.ovf  = path_truncated;
        expected_chars.push_back(cc);
      end
      char_count     = 0;
      path_absolute  = 1'b0;
      path_truncated = 1'b0;
      paths++;
    end
  endtask

  initial begin
    char_count     = 0;
    path_absolute  = 1'b0;
    path_truncated = 1'b0;
    fails          = 0;
    paths          = 0;
    seen           = 0;
  end

  // Predict on accepted input, compare on accepted output
  always @(posedge clk) begin
    clean_char_t want;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready)
        absorb_item(in_mon.in_char, in_mon.has_char, in_mon.in_last);
      if (out_mon.valid && out_mon.ready) begin
        seen++;
        if (expected_chars.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, got char %h last %b ovf %b",
                   $time, out_mon.out_char, out_mon.out_last, out_mon.overflow);
        end else begin
          want = expected_chars.pop_front();
          if (out_mon.out_char !== want.ch) begin
            fails++;
            $display("%0t: out_char mismatch, expected %h got %h",
                     $time, want.ch, out_mon.out_char);
          end
          if (out_mon.out_last !== want.last) begin
            fails++;
            $display("%0t: out_last mismatch, expected %b got %b",
                     $time, want.last, out_mon.out_last);
          end
          if (out_mon.overflow !== want.ovf) begin
            fails++;
            $display("%0t: overflow mismatch, expected %b got %b",
                     $time, want.ovf, out_mon.overflow);
          end
        end
      end
    end
    fail_count   <= fails;
    pending      <= expected_chars.size();
    paths_done   <= paths;
    results_seen <= seen;
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives paths into the lexical path normalizer: a short directed set of
// roots, dot and dot-dot cases, then random paths built from components,
// separator runs, empty items and over-long noise. Both channels idle at
// random. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int ITEM_TARGET = 260;
  localparam int DRAIN_WAIT  = 40;

  typedef struct packed {
    lpn_pkg::char_t ch;
    logic           has;
    logic           last;
  } path_item_t;

  logic clk;
  logic rst_n;

  lpn_in_if  in_ch ();
  lpn_out_if out_ch ();

  int fail_count;
  int pending;
  int paths_done;
  int results_seen;
  int items_sent;
  int send_calm;
  int recv_calm;

  path_item_t path_q[$];

  lexical_path_normalizer_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lpn_scoreboard i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .paths_done   (paths_done),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop for a hung run
  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

  // Wait per item, drawn at random, with stretches of back-to-back traffic
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) calm = $urandom_range(8, 30);
    return $urandom_range(0, 11);
  endfunction

  // Present one item after a random gap and hold it until accepted
  task automatic push_item(input lpn_pkg::char_t c, input logic has, input logic last);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.in_char  <= c;
    in_ch.has_char <= has;
    in_ch.in_last  <= last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Send a text path; optionally close it with an empty item
  task automatic send_text(input string s, input bit empty_close);
    for (int i = 0; i < s.len(); i++)
      push_item(s[i], 1'b1, (i == s.len() - 1) && !empty_close);
    if (empty_close || s.len() == 0) push_item(lpn_pkg::char_t'($urandom), 1'b0, 1'b1);
  endtask

  function automatic lpn_pkg::char_t pick_sep();
    return $urandom_range(0, 1) ? lpn_pkg::CH_SLASH : lpn_pkg::CH_BSLASH;
  endfunction

  // Name character: mostly letters and dots, sometimes any byte
  function automatic lpn_pkg::char_t pick_name_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return lpn_pkg::CH_DOT;
    if (r < 8) return lpn_pkg::char_t'(8'h61 + $urandom_range(0, 25));
    return lpn_pkg::char_t'($urandom_range(0, 255));
  endfunction

  function automatic path_item_t char_item(input lpn_pkg::char_t c);
    path_item_t it;
    it.ch   = c;
    it.has  = 1'b1;
    it.last = 1'b0;
    return it;
  endfunction

  // Build one random path into path_q
  task automatic make_path(input bit longer);
    int ncomp;
    int clen;
    int r;
    path_item_t it;
    path_q.delete();
    if (longer || $urandom_range(0, 9) == 0) begin
      // noise: raw bytes biased toward separators and dots
      clen = longer ? $urandom_range(58, 80) : $urandom_range(1, 12);
      for (int i = 0; i < clen; i++) begin
        r = $urandom_range(0, 5);
        path_q.push_back(char_item(r < 2 ? pick_sep() :
                                   r < 4 ? pick_name_char() : lpn_pkg::CH_DOT));
      end
    end else begin
      if ($urandom_range(0, 1))
        repeat ($urandom_range(1, 3)) path_q.push_back(char_item(pick_sep()));
      ncomp = $urandom_range(0, 6);
      for (int k = 0; k < ncomp; k++) begin
        r = $urandom_range(0, 9);
        if (r < 2) begin
          path_q.push_back(char_item(lpn_pkg::CH_DOT));
        end else if (r < 5) begin
          path_q.push_back(char_item(lpn_pkg::CH_DOT));
          path_q.push_back(char_item(lpn_pkg::CH_DOT));
        end else begin
          clen = $urandom_range(1, 4);
          for (int i = 0; i < clen; i++) path_q.push_back(char_item(pick_name_char()));
        end
        if ($urandom_range(0, 9) == 0) begin
          it.ch   = lpn_pkg::char_t'($urandom);
          it.has  = 1'b0;
          it.last = 1'b0;
          path_q.push_back(it);
        end
        if (k < ncomp - 1 || $urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) path_q.push_back(char_item(pick_sep()));
      end
    end
    // close on the last character or on an extra empty item
    if (path_q.size() == 0 || !path_q[$].has || $urandom_range(0, 3) == 0) begin
      it.ch   = lpn_pkg::char_t'($urandom);
      it.has  = 1'b0;
      it.last = 1'b1;
      path_q.push_back(it);
    end else begin
      path_q[$].last = 1'b1;
    end
  endtask

  // Result side: random stalls between items
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    recv_calm = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_wait(recv_calm);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Stimulus and verdict
  initial begin
    bit first;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.in_char  <= '0;
    in_ch.has_char <= 1'b0;
    in_ch.in_last  <= 1'b0;
    items_sent = 0;
    send_calm  = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty path, bare backslash root, dot-dot at an absolute root,
    // kept leading dot-dots closed by an empty item, dot and pop in a name,
    // extreme byte values
    send_text("", 1'b1);
    send_text("\\", 1'b0);
    send_text("\\..\\a", 1'b0);
    send_text("..\\..", 1'b1);
    send_text("/../a/.", 1'b0);
    send_text("a/./b/..", 1'b0);
    push_item(8'hFF, 1'b1, 1'b0);
    push_item(8'h00, 1'b1, 1'b1);

    // random paths; the first one is a long noise path that may overrun the store
    first = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      make_path(first || $urandom_range(0, 14) == 0);
      first = 1'b0;
      foreach (path_q[i]) push_item(path_q[i].ch, path_q[i].has, path_q[i].last);
    end
    in_ch.valid <= 1'b0;

    // drain the outstanding results
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d paths from %0d input items, %0d result characters compared",
             paths_done, items_sent, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
